>>> hw/rtl/tesb_pkg.sv
// ----------------------------------------------------------------------------
// tesb_pkg
// Shared types, constants and helpers for the touch event to screen button
// core: event codes, register indexes, reset values and the Y fold.
// ----------------------------------------------------------------------------
package tesb_pkg;

    // Event decoding
    localparam logic [4:0] EV_TYPE_KEY   = 5'd1;
    localparam logic [4:0] EV_TYPE_ABS   = 5'd3;
    localparam logic [9:0] EV_CODE_X     = 10'd53;
    localparam logic [9:0] EV_CODE_Y     = 10'd54;
    localparam logic [9:0] EV_CODE_TOUCH = 10'd330;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_RAW_X_RANGE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAW_Y_RANGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_GAP    = 3'd6;

    localparam logic [CFG_DATA_W-1:0] RST_RAW_X_RANGE   = 12'd800;
    localparam logic [CFG_DATA_W-1:0] RST_RAW_Y_RANGE   = 12'd480;
    localparam logic [CFG_DATA_W-1:0] RST_SCREEN_WIDTH  = 12'd1024;
    localparam logic [CFG_DATA_W-1:0] RST_SCREEN_HEIGHT = 12'd600;
    localparam logic [CFG_DATA_W-1:0] RST_BUTTON_WIDTH  = 12'd204;
    localparam logic [CFG_DATA_W-1:0] RST_BUTTON_HEIGHT = 12'd100;
    localparam logic [CFG_DATA_W-1:0] RST_BUTTON_GAP    = 12'd102;

    // Datapath sizes
    localparam int unsigned VAL_W   = 16;                 // raw axis value
    localparam int unsigned WORK_W  = 15;                 // positive working axis
    localparam int unsigned DVD_W   = WORK_W + CFG_DATA_W; // axis * screen
    localparam int unsigned CNT_W   = $clog2(DVD_W);

    localparam logic [CNT_W-1:0]         DIV_LAST     = CNT_W'(DVD_W - 1);
    localparam logic signed [VAL_W-1:0]  DEFAULT_AXIS = 16'sd200;
    localparam logic signed [VAL_W-1:0]  PAD          = 16'sd50;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_CLAMP,
        ST_HIT
    } t_state;

    // Fold a Y value about half the raw Y span
    function automatic logic signed [VAL_W-1:0] fold_y(
        input logic signed [VAL_W-1:0] v,
        input logic [CFG_DATA_W-1:0]   span
    );
        logic signed [VAL_W:0] v_ext;
        logic signed [VAL_W:0] half;
        logic signed [VAL_W:0] diff;
        v_ext = $signed({v[VAL_W-1], v});
        half  = $signed({5'b0, 1'b0, span[CFG_DATA_W-1:1]});
        diff  = $signed({5'b0, span}) - v_ext;
        if (v_ext > half) begin
            return $signed(diff[VAL_W-1:0]);
        end
        return v;
    endfunction

endpackage

>>> hw/rtl/touch_event_to_screen_button_core.sv
// ----------------------------------------------------------------------------
// touch_event_to_screen_button_core
// Caches raw touch X/Y events; on touch release scales the point to screen
// pixels with a shared restoring divider, clamps it and hit-tests it against
// the Start and Exit buttons.
// ----------------------------------------------------------------------------
// Sequence: axis and ignored events are taken while idle. A release that yields a
//   result runs, for X and then for Y, a multiply, 27 divide steps and a clamp,
//   then a hit test that loads the output register once it is free.
// Throughput: one item at a time; the shared 27-step divider sets the rate.
// Reset: synchronous, active low; clears cached axes, output valid and loads the
//   register reset values.
module touch_event_to_screen_button_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [tesb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tesb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input transactions
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [4:0]                          i_event_type,
    input  logic [9:0]                          i_event_code,
    input  logic signed [15:0]                  i_event_value,
    // output transactions
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [11:0]                         o_screen_x,
    output logic [11:0]                         o_screen_y,
    output logic                                o_button_choice
);
    import tesb_pkg::*;

    // Registers
    logic [CFG_DATA_W-1:0]   r_raw_x, r_raw_y, r_scr_w, r_scr_h, r_btn_w, r_btn_h, r_gap;
    logic signed [VAL_W-1:0] r_held_x, r_held_y;
    t_state                  r_state, n_state;
    logic [WORK_W-1:0]       r_work_x, r_work_y;
    logic                    r_axis;        // 0: X pass, 1: Y pass
    logic [CNT_W-1:0]        r_count;
    logic [DVD_W-1:0]        r_quo;
    logic [CFG_DATA_W-1:0]   r_rem;
    logic [CFG_DATA_W-1:0]   r_px, r_py;
    logic                    r_out_valid;
    logic [11:0]             r_out_x, r_out_y;
    logic                    r_out_choice;

    // Control
    logic in_accept, out_free, ld_out;

    // Event decode and release preparation
    logic                    is_x, is_y, is_release, rel_ok;
    logic signed [VAL_W-1:0] new_held_y, wx, wy;

    always_comb begin
        is_x       = (i_event_type == EV_TYPE_ABS) && (i_event_code == EV_CODE_X);
        is_y       = (i_event_type == EV_TYPE_ABS) && (i_event_code == EV_CODE_Y);
        is_release = (i_event_type == EV_TYPE_KEY) && (i_event_code == EV_CODE_TOUCH)
                     && (i_event_value == 16'sd0);
        new_held_y = fold_y(r_held_y, r_raw_y);
        wx         = (r_held_x == 16'sd0) ? DEFAULT_AXIS : r_held_x;
        wy         = fold_y((new_held_y == 16'sd0) ? DEFAULT_AXIS : new_held_y, r_raw_y);
        rel_ok     = !wx[VAL_W-1] && (wx != 16'sd0) && !wy[VAL_W-1] && (wy != 16'sd0)
                     && (r_raw_x != '0) && (r_raw_y != '0)
                     && (r_scr_w != '0) && (r_scr_h != '0);
    end

    // Shared unit operand select
    logic [WORK_W-1:0]     cur_work;
    logic [CFG_DATA_W-1:0] cur_screen, cur_range;

    always_comb begin
        cur_work   = r_axis ? r_work_y : r_work_x;
        cur_screen = r_axis ? r_scr_h : r_scr_w;
        cur_range  = r_axis ? r_raw_y : r_raw_x;
    end

    // Restoring divide step
    logic [CFG_DATA_W:0]   rem_sh;
    logic                  q_bit;
    logic [CFG_DATA_W-1:0] rem_nxt;
    logic [CFG_DATA_W-1:0] clamp_val;

    always_comb begin
        rem_sh    = {r_rem, r_quo[DVD_W-1]};
        q_bit     = rem_sh >= {1'b0, cur_range};
        rem_nxt   = q_bit ? CFG_DATA_W'(rem_sh - {1'b0, cur_range})
                          : rem_sh[CFG_DATA_W-1:0];
        clamp_val = (r_quo >= DVD_W'(cur_screen)) ? (cur_screen - 12'd1)
                                                  : r_quo[CFG_DATA_W-1:0];
    end

    // Button hit test
    logic signed [VAL_W-1:0] sw_s, sh_s, bw_s, bh_s, gap_s, px_s, py_s;
    logic signed [VAL_W-1:0] top, span_d, sx, ex;
    logic                    row_hit, start_hit, exit_hit, choice;

    always_comb begin
        sw_s      = $signed({4'b0, r_scr_w});
        sh_s      = $signed({4'b0, r_scr_h});
        bw_s      = $signed({4'b0, r_btn_w});
        bh_s      = $signed({4'b0, r_btn_h});
        gap_s     = $signed({4'b0, r_gap});
        px_s      = $signed({4'b0, r_px});
        py_s      = $signed({4'b0, r_py});
        top       = sh_s - bh_s - PAD;
        span_d    = sw_s - (bw_s <<< 1) - gap_s;
        // halve, rounding toward zero
        sx        = (span_d + $signed({15'b0, span_d[VAL_W-1]})) >>> 1;
        ex        = sx + bw_s + gap_s;
        row_hit   = (py_s >= top - PAD) && (py_s <= top + bh_s + PAD);
        start_hit = row_hit && (px_s >= sx - PAD) && (px_s <= sx + bw_s + PAD);
        exit_hit  = row_hit && (px_s >= ex - PAD) && (px_s <= ex + bw_s + PAD);
        if (start_hit) begin
            choice = 1'b0;
        end else if (exit_hit) begin
            choice = 1'b1;
        end else begin
            choice = !(r_px < {1'b0, r_scr_w[CFG_DATA_W-1:1]});
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept && is_release && rel_ok) n_state = ST_MUL;
            end
            ST_MUL:   n_state = ST_DIV;
            ST_DIV: begin
                if (r_count == DIV_LAST) n_state = ST_CLAMP;
            end
            ST_CLAMP: n_state = r_axis ? ST_HIT : ST_MUL;
            ST_HIT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        out_free   = !r_out_valid || !i_out_stall;
        o_in_stall = (r_state != ST_IDLE);
        in_accept  = i_in_valid && (r_state == ST_IDLE);
        ld_out     = (r_state == ST_HIT) && out_free;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_x <= RST_RAW_X_RANGE;
            r_raw_y <= RST_RAW_Y_RANGE;
            r_scr_w <= RST_SCREEN_WIDTH;
            r_scr_h <= RST_SCREEN_HEIGHT;
            r_btn_w <= RST_BUTTON_WIDTH;
            r_btn_h <= RST_BUTTON_HEIGHT;
            r_gap   <= RST_BUTTON_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RAW_X_RANGE:   r_raw_x <= i_cfg_data;
                CFG_RAW_Y_RANGE:   r_raw_y <= i_cfg_data;
                CFG_SCREEN_WIDTH:  r_scr_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_scr_h <= i_cfg_data;
                CFG_BUTTON_WIDTH:  r_btn_w <= i_cfg_data;
                CFG_BUTTON_HEIGHT: r_btn_h <= i_cfg_data;
                CFG_BUTTON_GAP:    r_gap   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control state: state, cached axes, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_held_x    <= '0;
            r_held_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                if (is_x) begin
                    r_held_x <= i_event_value;
                end else if (is_y) begin
                    r_held_y <= fold_y(i_event_value, r_raw_y);
                end else if (is_release) begin
                    r_held_y <= new_held_y;
                end
            end
            if (ld_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath: working axes, shared multiply/divide, clamp, output register
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_work_x <= wx[WORK_W-1:0];
                r_work_y <= wy[WORK_W-1:0];
                r_axis   <= 1'b0;
            end
            ST_MUL: begin
                r_quo   <= DVD_W'(cur_work * cur_screen);
                r_rem   <= '0;
                r_count <= '0;
            end
            ST_DIV: begin
                r_quo   <= {r_quo[DVD_W-2:0], q_bit};
                r_rem   <= rem_nxt;
                r_count <= r_count + 1'b1;
            end
            ST_CLAMP: begin
                if (r_axis) r_py <= clamp_val;
                else        r_px <= clamp_val;
                r_axis <= 1'b1;
            end
            ST_HIT: begin
                if (out_free) begin
                    r_out_x      <= r_px;
                    r_out_y      <= r_py;
                    r_out_choice <= choice;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_screen_x      = r_out_x;
    assign o_screen_y      = r_out_y;
    assign o_button_choice = r_out_choice;

`ifndef SYNTHESIS
    // divider step count stays within the dividend width
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_count <= DIV_LAST))
        else $error("divider step count out of range");

    // last divide step hands over to the clamp
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_count == DIV_LAST) |=> (r_state == ST_CLAMP))
        else $error("divider did not finish into clamp");

    // a new result only appears after the hit test
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_HIT))
        else $error("result raised outside hit test");

    // hit test with a free output register loads it and returns to idle
    a_hit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HIT && out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("hit test did not deliver result");
`endif

endmodule
